FILE: src/assert_macros.svh
// Assertion macros for the RTL; included by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

FILE: src/lps_pkg.sv
// Package: widths, codes and state type of the linear-probe hash set.
`default_nettype none

package lps_pkg;

  localparam int KEY_W           = 32;
  localparam int ENTRY_W         = 11;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int LOAD_NUM        = 7;
  localparam int LOAD_DEN        = 10;
  localparam int STEP_W          = 6;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: src/lps_if.sv
// Request and response channel interfaces of the hash set.
`default_nettype none

interface lps_req_if;
  import lps_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] key;

  modport source (output valid, opcode, key, input ready);
  modport sink   (input valid, opcode, key, output ready);
endinterface

interface lps_rsp_if;
  import lps_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit_or_added;
  logic               status;
  logic [ENTRY_W-1:0] entry_count;

  modport source (output valid, hit_or_added, status, entry_count, input ready);
  modport sink   (input valid, hit_or_added, status, entry_count, output ready);
endinterface

`default_nettype wire

FILE: src/lps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/lps_hash.sv
// Home-slot unit: multiplicative hash, then reduction modulo the table depth.
`default_nettype none

module lps_hash #(
  parameter int TABLE_DEPTH = lps_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lps_pkg::KEY_W-1:0]      key,
  output logic                                done,
  output logic      [$clog2(TABLE_DEPTH)-1:0] idx
);
  import lps_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam bit POW2   = (TABLE_DEPTH == (1 << IDX_W));
  // other depths: quotient estimate from a reciprocal, remainder, then one
  // conditional subtract (the estimate is low by at most one)
  localparam int NSTEP  = POW2 ? 0 : 3;
  localparam logic [STEP_W-1:0] STEP_QUOT = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_REM  = STEP_W'(2);
  localparam logic [KEY_W-1:0]  RECIP     = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_DEPTH));
  localparam logic [KEY_W-1:0]  DEPTH_K   = KEY_W'(TABLE_DEPTH);

  logic                busy;
  logic [STEP_W-1:0]   steps;
  logic [KEY_W-1:0]    rem;
  logic [KEY_W-1:0]    quo;
  logic [2*KEY_W-1:0]  recip_prod;
  logic [KEY_W-1:0]    quo_x_depth;

  assign recip_prod  = {{KEY_W{1'b0}}, rem} * {{KEY_W{1'b0}}, RECIP};
  assign quo_x_depth = quo * DEPTH_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && steps == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= key * HASH_MULT;
      steps <= STEP_W'(NSTEP);
    end else if (busy && steps != '0) begin
      if (steps == STEP_QUOT) begin
        quo <= recip_prod[2*KEY_W-1:KEY_W];
      end else if (steps == STEP_REM) begin
        rem <= rem - quo_x_depth;
      end else if (rem >= DEPTH_K) begin
        rem <= rem - DEPTH_K;
      end
      steps <= steps - STEP_W'(1);
    end
  end

  assign done = busy && (steps == '0);
  assign idx  = rem[IDX_W-1:0];

endmodule

`default_nettype wire

FILE: src/linear_probe_hash_set_core.sv
// Top level: linear-probing hash set of nonzero 32-bit keys in one slot RAM.
//
// Usage
//   req channel carries opcode (0 lookup, 1 add) and key; rsp channel returns
//   hit_or_added, status (1 = add refused, table full) and entry_count.
//   One response per request, in request order.
// Reset
//   rst (synchronous) clears the key count, then a clearing pass writes zero
//   to every slot, one per cycle; req.ready stays low during the pass.
// Request flow
//   A request is hashed, then slots are probed (one or more) from the home
//   slot on; the result is loaded into the response register and a new
//   request is taken the cycle after. Depths other than a power of two add
//   the hash reduction steps. Each probe is one read of the single-read slot
//   RAM. Key zero and refused adds skip hash and search.
// Stall
//   The response sits in an output register; the next request is taken while
//   it waits. A second finished result holds in the FIN state until the
//   receiver takes the first one.
`default_nettype none
`include "assert_macros.svh"

module linear_probe_hash_set_core #(
  parameter int TABLE_DEPTH = lps_pkg::DEF_TABLE_DEPTH
) (
  input wire logic  clk,
  input wire logic  rst,
  lps_req_if.sink   req,
  lps_rsp_if.source rsp
);
  import lps_pkg::*;

  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  // adds are refused once count + 1 reaches 70 percent of the depth
  localparam int LIMIT_CNT = (TABLE_DEPTH * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN - 1;
  localparam int CNT_W     = (LIMIT_CNT > 0) ? $clog2(LIMIT_CNT + 1) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t             state, state_next;
  logic               op;
  logic [KEY_W-1:0]   key;
  logic [IDX_W-1:0]   idx, idx_next, idx_inc;
  logic [IDX_W-1:0]   probe_n, probe_n_next;
  logic [IDX_W-1:0]   clr_idx, clr_idx_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               res_hit, res_hit_next;
  logic               res_status, res_status_next;
  logic               out_load;
  logic               at_limit;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [KEY_W-1:0]   ram_wdata, ram_rdata;

  logic               hash_start, hash_done;
  logic [IDX_W-1:0]   hash_idx;

  // ---------------------------------------------------------------- units
  lps_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lps_hash #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (req.key),
    .done  (hash_done),
    .idx   (hash_idx)
  );

  // probe walk wraps from the last slot to slot 0
  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  // first probe reads the home slot, later probes the next slot
  assign ram_raddr = (state == ST_HASH) ? hash_idx : idx_inc;
  assign at_limit  = (count >= CNT_W'(LIMIT_CNT));
  assign req.ready = (state == ST_IDLE);

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      count   <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    probe_n    <= probe_n_next;
    res_hit    <= res_hit_next;
    res_status <= res_status_next;
    if (req.valid && req.ready) begin
      op  <= req.opcode;
      key <= req.key;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    probe_n_next    = probe_n;
    clr_idx_next    = clr_idx;
    count_next      = count;
    res_hit_next    = res_hit;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = key;
    hash_start      = 1'b0;
    out_load        = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end else begin
          clr_idx_next = clr_idx + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (req.valid) begin
          priority if (req.key == '0) begin
            res_hit_next    = 1'b0;
            res_status_next = STATUS_OK;
            state_next      = ST_FIN;
          end else if (req.opcode == OP_ADD && at_limit) begin
            res_hit_next    = 1'b0;
            res_status_next = STATUS_FULL;
            state_next      = ST_FIN;
          end else begin
            hash_start   = 1'b1;
            probe_n_next = '0;
            state_next   = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        if (hash_done) begin
          idx_next   = hash_idx;
          state_next = ST_PROBE;
        end
      end

      ST_PROBE: begin
        // ram_rdata holds the slot at idx
        priority if (ram_rdata == key) begin
          res_hit_next    = (op == OP_LOOKUP);
          res_status_next = STATUS_OK;
          state_next      = ST_FIN;
        end else if (ram_rdata == '0) begin
          if (op == OP_ADD) begin
            ram_we     = 1'b1;
            count_next = count + CNT_W'(1);
          end
          res_hit_next    = (op == OP_ADD);
          res_status_next = STATUS_OK;
          state_next      = ST_FIN;
        end else if (probe_n == LAST_IDX) begin
          res_hit_next    = 1'b0;
          res_status_next = (op == OP_ADD) ? STATUS_FULL : STATUS_OK;
          state_next      = ST_FIN;
        end else begin
          idx_next     = idx_inc;
          probe_n_next = probe_n + IDX_W'(1);
        end
      end

      ST_FIN: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.hit_or_added <= res_hit;
      rsp.status       <= res_status;
      rsp.entry_count  <= ENTRY_W'(count);
    end
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_CLK(a_count_limit, count <= CNT_W'(LIMIT_CNT), "key count above load limit")
  `ASSERT_CLK(a_count_only_on_insert, state != ST_PROBE |=> $stable(count), "count moved outside probe")
  `ASSERT_CLK(a_write_into_empty, (ram_we && state != ST_CLEAR) |-> (state == ST_PROBE && ram_rdata == '0 && op == OP_ADD), "slot write not into an empty slot")
  `ASSERT_NEVER(a_stray_hash_done, hash_done && state != ST_HASH, "hash result outside hash wait")

endmodule

`default_nettype wire
